// ----- hdl/fbpa_pkg.sv -----
// shared types, constants and control word layout for the block pool allocator
`timescale 1ns / 1ps

package fbpa_pkg;

    localparam int ADDR_W         = 32;
    localparam int SIZE_W         = 16;
    localparam int CNT_W          = 11;
    localparam int OP_W           = 2;
    localparam int CFG_IDX_W      = 2;
    localparam int PC_W           = 4;
    localparam int POOL_DEPTH_DEF = 1024;
    localparam int OUT_DATA_W     = ((ADDR_W + CNT_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_COUNT = 2'd2;

    localparam logic [CNT_W-1:0]  TOTAL_MAX       = 11'd2047;
    localparam logic [SIZE_W-1:0] MIN_CHUNK       = 16'd8;
    localparam logic [SIZE_W-1:0] CHUNK_BYTES_RST = 16'd8;
    localparam logic [CNT_W-1:0]  CHUNK_COUNT_RST = 11'd1024;

    typedef enum logic [3:0] {
        A_NONE,
        A_ACCEPT,
        A_ALLOC_MUL,
        A_ALLOC_POP,
        A_FREE_PREP,
        A_DIV_STEP,
        A_FREE_PUSH,
        A_INIT_START,
        A_INIT_WRITE,
        A_EMIT
    } act_t;

    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_INPUT,
        C_OP_ALLOC,
        C_OP_FREE,
        C_OP_INIT,
        C_HEAD_EMPTY,
        C_FREE_BAD,
        C_DIV_MORE,
        C_REM_NZ,
        C_COUNT_ZERO,
        C_INIT_MORE,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        act_t            act;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic no_input;
        logic op_alloc;
        logic op_free;
        logic op_init;
        logic head_empty;
        logic free_bad;
        logic div_more;
        logic rem_nz;
        logic count_zero;
        logic init_more;
        logic out_busy;
    } flags_t;

endpackage

// ----- hdl/fbpa_ram.sv -----
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/fbpa_seq.sv -----
// microcode sequencer: step counter, control store and jump logic
`timescale 1ns / 1ps

module fbpa_seq (
    input  logic            aclk,
    input  logic            aresetn,
    input  fbpa_pkg::flags_t flags,
    output fbpa_pkg::ctrl_t  ctrl
);

    import fbpa_pkg::*;

    localparam logic [PC_W-1:0] S_IDLE       = 4'd0;
    localparam logic [PC_W-1:0] S_DISP_ALLOC = 4'd1;
    localparam logic [PC_W-1:0] S_DISP_FREE  = 4'd2;
    localparam logic [PC_W-1:0] S_DISP_INIT  = 4'd3;
    localparam logic [PC_W-1:0] S_DISP_OTHER = 4'd4;
    localparam logic [PC_W-1:0] S_ALLOC_READ = 4'd5;
    localparam logic [PC_W-1:0] S_ALLOC_POP  = 4'd6;
    localparam logic [PC_W-1:0] S_FREE_PREP  = 4'd7;
    localparam logic [PC_W-1:0] S_FREE_RANGE = 4'd8;
    localparam logic [PC_W-1:0] S_FREE_DIV   = 4'd9;
    localparam logic [PC_W-1:0] S_FREE_ALIGN = 4'd10;
    localparam logic [PC_W-1:0] S_FREE_PUSH  = 4'd11;
    localparam logic [PC_W-1:0] S_INIT_START = 4'd13;
    localparam logic [PC_W-1:0] S_INIT_LOOP  = 4'd14;
    localparam logic [PC_W-1:0] S_EMIT       = 4'd15;

    function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
        ctrl_t w;
        case (pc)
            S_IDLE:       w = '{act: A_ACCEPT,     cond: C_NO_INPUT,   target: S_IDLE};
            S_DISP_ALLOC: w = '{act: A_NONE,       cond: C_OP_ALLOC,   target: S_ALLOC_READ};
            S_DISP_FREE:  w = '{act: A_NONE,       cond: C_OP_FREE,    target: S_FREE_PREP};
            S_DISP_INIT:  w = '{act: A_NONE,       cond: C_OP_INIT,    target: S_INIT_START};
            S_DISP_OTHER: w = '{act: A_NONE,       cond: C_ALWAYS,     target: S_EMIT};
            S_ALLOC_READ: w = '{act: A_ALLOC_MUL,  cond: C_HEAD_EMPTY, target: S_EMIT};
            S_ALLOC_POP:  w = '{act: A_ALLOC_POP,  cond: C_ALWAYS,     target: S_EMIT};
            S_FREE_PREP:  w = '{act: A_FREE_PREP,  cond: C_NEXT,       target: S_IDLE};
            S_FREE_RANGE: w = '{act: A_NONE,       cond: C_FREE_BAD,   target: S_EMIT};
            S_FREE_DIV:   w = '{act: A_DIV_STEP,   cond: C_DIV_MORE,   target: S_FREE_DIV};
            S_FREE_ALIGN: w = '{act: A_NONE,       cond: C_REM_NZ,     target: S_EMIT};
            S_FREE_PUSH:  w = '{act: A_FREE_PUSH,  cond: C_ALWAYS,     target: S_EMIT};
            S_INIT_START: w = '{act: A_INIT_START, cond: C_COUNT_ZERO, target: S_EMIT};
            S_INIT_LOOP:  w = '{act: A_INIT_WRITE, cond: C_INIT_MORE,  target: S_INIT_LOOP};
            S_EMIT:       w = '{act: A_EMIT,       cond: C_OUT_BUSY,   target: S_EMIT};
            default:      w = '{act: A_NONE,       cond: C_ALWAYS,     target: S_IDLE};
        endcase
        return w;
    endfunction

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            take;

    assign ctrl = ucode(pc_reg);

    always_comb begin
        case (ctrl.cond)
            C_NEXT:       take = 1'b0;
            C_ALWAYS:     take = 1'b1;
            C_NO_INPUT:   take = flags.no_input;
            C_OP_ALLOC:   take = flags.op_alloc;
            C_OP_FREE:    take = flags.op_free;
            C_OP_INIT:    take = flags.op_init;
            C_HEAD_EMPTY: take = flags.head_empty;
            C_FREE_BAD:   take = flags.free_bad;
            C_DIV_MORE:   take = flags.div_more;
            C_REM_NZ:     take = flags.rem_nz;
            C_COUNT_ZERO: take = flags.count_zero;
            C_INIT_MORE:  take = flags.init_more;
            C_OUT_BUSY:   take = flags.out_busy;
            default:      take = 1'b0;
        endcase
    end

    // last step wraps back to idle
    assign pc_next = take ? ctrl.target : pc_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= S_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// ----- hdl/fixed_block_pool_allocator_unit.sv -----
// top level of the fixed block pool allocator with its datapath
`timescale 1ns / 1ps

// channel  | direction | ports                                   | word
// ---------+-----------+-----------------------------------------+----------------------------
// input    | in        | s_tvalid s_tready s_tdata s_tuser       | operation, free address
// result   | out       | m_tvalid m_tready m_tdata m_tuser       | ok, chunk address, count
// config   | in        | cfg_valid cfg_ready cfg_index cfg_data  | register index and value
//
// one word at a time through a microcoded step counter
// free runs 11 restoring divide steps on the offset from the pool base
// initialize writes one link per cycle through the ram write port
// synchronous active-low reset; the link ram holds no reset state, no clearing pass
// a waiting result is held in the output register while the next word is accepted

module fixed_block_pool_allocator_unit #(
    parameter int POOL_DEPTH = fbpa_pkg::POOL_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [fbpa_pkg::ADDR_W-1:0]      s_tdata,   // address
    input  logic [fbpa_pkg::OP_W-1:0]        s_tuser,   // operation
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [fbpa_pkg::OUT_DATA_W-1:0]  m_tdata,   // chunk_address, free_count, zero pad
    output logic                             m_tuser,   // ok
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fbpa_pkg::ADDR_W-1:0]      cfg_data
);

    import fbpa_pkg::*;

    localparam int IDX_W   = $clog2(POOL_DEPTH);
    localparam int LINK_W  = IDX_W + 1;
    localparam int MUL_A_W = (IDX_W > CNT_W) ? IDX_W : CNT_W;
    localparam int PROD_W  = MUL_A_W + SIZE_W;
    localparam int K_W     = $clog2(CNT_W);
    localparam logic [CNT_W-1:0] DEPTH_CAP =
        (POOL_DEPTH > int'(TOTAL_MAX)) ? TOTAL_MAX : CNT_W'(POOL_DEPTH);

    function automatic logic [IDX_W-1:0] to_idx(input logic [CNT_W-1:0] x);
        logic [IDX_W+CNT_W-1:0] w;
        w = {{IDX_W{1'b0}}, x};
        return w[IDX_W-1:0];
    endfunction

    ctrl_t  ctrl;
    flags_t flags;

    // configuration
    logic [ADDR_W-1:0] base_reg,   base_next;
    logic [SIZE_W-1:0] csize_reg,  csize_next;
    logic [CNT_W-1:0]  ccount_reg, ccount_next;

    // list state
    logic [IDX_W-1:0]  head_reg,  head_next;
    logic              hv_reg,    hv_next;
    logic [CNT_W-1:0]  total_reg, total_next;

    // working registers
    logic [OP_W-1:0]   op_reg,    op_next;
    logic [ADDR_W-1:0] addr_reg,  addr_next;
    logic              ok_reg,    ok_next;
    logic [ADDR_W-1:0] res_reg,   res_next;
    logic [PROD_W-1:0] prod_reg,  prod_next;
    logic [ADDR_W-1:0] rem_reg,   rem_next;
    logic              chk_reg,   chk_next;
    logic [CNT_W-1:0]  quo_reg,   quo_next;
    logic [K_W-1:0]    k_reg,     k_next;
    logic [CNT_W-1:0]  i_reg,     i_next;

    // output register
    logic              mtv_reg,    mtv_next;
    logic              mok_reg,    mok_next;
    logic [ADDR_W-1:0] maddr_reg,  maddr_next;
    logic [CNT_W-1:0]  mcount_reg, mcount_next;

    logic [SIZE_W-1:0]  size_eff;
    logic [CNT_W-1:0]   count_eff;
    logic [MUL_A_W-1:0] mul_a;
    logic [PROD_W-1:0]  mul_out;
    logic [ADDR_W:0]    size_sh;
    logic [ADDR_W:0]    trial;
    logic [CNT_W-1:0]   i_plus;
    logic               init_more;
    logic               out_free;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [LINK_W-1:0]  ram_wdata;
    logic [LINK_W-1:0]  ram_rdata;

    fbpa_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    fbpa_ram #(
        .WIDTH (LINK_W),
        .DEPTH (POOL_DEPTH)
    ) u_link_ram (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (head_reg),
        .rd_data (ram_rdata)
    );

    assign size_eff  = (csize_reg < MIN_CHUNK) ? MIN_CHUNK : csize_reg;
    assign count_eff = (ccount_reg > DEPTH_CAP) ? DEPTH_CAP : ccount_reg;

    // shared multiplier: head index for allocate, count for the pool span
    assign mul_a   = (ctrl.act == A_FREE_PREP) ? MUL_A_W'(count_eff) : MUL_A_W'(head_reg);
    assign mul_out = mul_a * size_eff;

    assign size_sh = {{(ADDR_W + 1 - SIZE_W){1'b0}}, size_eff} << k_reg;
    assign trial   = {1'b0, rem_reg} - size_sh;

    assign i_plus    = i_reg + 1'b1;
    assign init_more = (i_plus != count_eff);
    assign out_free  = !mtv_reg || m_tready;

    assign s_tready  = (ctrl.act == A_ACCEPT) && aresetn;
    assign cfg_ready = 1'b1;

    always_comb begin
        flags.no_input   = !s_tvalid;
        flags.op_alloc   = (op_reg == OP_ALLOC);
        flags.op_free    = (op_reg == OP_FREE);
        flags.op_init    = (op_reg == OP_INIT);
        flags.head_empty = !hv_reg;
        flags.free_bad   = !chk_reg || (rem_reg >= ADDR_W'(prod_reg));
        flags.div_more   = (k_reg != '0);
        flags.rem_nz     = (rem_reg != '0);
        flags.count_zero = (count_eff == '0);
        flags.init_more  = init_more;
        flags.out_busy   = !out_free;
    end

    always_comb begin
        base_next   = base_reg;
        csize_next  = csize_reg;
        ccount_next = ccount_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_POOL_BASE:   base_next   = cfg_data;
                REG_CHUNK_BYTES: csize_next  = cfg_data[SIZE_W-1:0];
                REG_CHUNK_COUNT: ccount_next = cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        head_next   = head_reg;
        hv_next     = hv_reg;
        total_next  = total_reg;
        op_next     = op_reg;
        addr_next   = addr_reg;
        ok_next     = ok_reg;
        res_next    = res_reg;
        prod_next   = prod_reg;
        rem_next    = rem_reg;
        chk_next    = chk_reg;
        quo_next    = quo_reg;
        k_next      = k_reg;
        i_next      = i_reg;
        mtv_next    = mtv_reg && !m_tready;
        mok_next    = mok_reg;
        maddr_next  = maddr_reg;
        mcount_next = mcount_reg;
        ram_we      = 1'b0;
        ram_waddr   = to_idx(i_reg);
        ram_wdata   = init_more ? {1'b1, to_idx(i_plus)} : '0;

        case (ctrl.act)
            A_ACCEPT: begin
                if (s_tvalid) begin
                    op_next   = s_tuser;
                    addr_next = s_tdata;
                    ok_next   = 1'b0;
                    res_next  = '0;
                end
            end
            A_ALLOC_MUL: begin
                prod_next = mul_out;
            end
            A_ALLOC_POP: begin
                res_next  = base_reg + ADDR_W'(prod_reg);
                head_next = ram_rdata[IDX_W-1:0];
                hv_next   = ram_rdata[IDX_W];
                if (total_reg != '0) begin
                    total_next = total_reg - 1'b1;
                end
                ok_next = 1'b1;
            end
            A_FREE_PREP: begin
                prod_next = mul_out;
                rem_next  = addr_reg - base_reg;
                chk_next  = (addr_reg != '0) && (addr_reg >= base_reg);
                k_next    = K_W'(CNT_W - 1);
                quo_next  = '0;
            end
            A_DIV_STEP: begin
                if (!trial[ADDR_W]) begin
                    rem_next = trial[ADDR_W-1:0];
                    quo_next = quo_reg | (CNT_W'(1) << k_reg);
                end
                k_next = k_reg - 1'b1;
            end
            A_FREE_PUSH: begin
                ram_we    = 1'b1;
                ram_waddr = to_idx(quo_reg);
                ram_wdata = {hv_reg, head_reg};
                head_next = to_idx(quo_reg);
                hv_next   = 1'b1;
                if (total_reg != TOTAL_MAX) begin
                    total_next = total_reg + 1'b1;
                end
                ok_next = 1'b1;
            end
            A_INIT_START: begin
                i_next     = '0;
                head_next  = '0;
                hv_next    = (count_eff != '0);
                total_next = count_eff;
                ok_next    = (count_eff != '0);
            end
            A_INIT_WRITE: begin
                ram_we = 1'b1;
                i_next = i_plus;
            end
            A_EMIT: begin
                if (out_free) begin
                    mtv_next    = 1'b1;
                    mok_next    = ok_reg;
                    maddr_next  = res_reg;
                    mcount_next = total_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg   <= '0;
            csize_reg  <= CHUNK_BYTES_RST;
            ccount_reg <= CHUNK_COUNT_RST;
            head_reg   <= '0;
            hv_reg     <= 1'b0;
            total_reg  <= '0;
            mtv_reg    <= 1'b0;
        end else begin
            base_reg   <= base_next;
            csize_reg  <= csize_next;
            ccount_reg <= ccount_next;
            head_reg   <= head_next;
            hv_reg     <= hv_next;
            total_reg  <= total_next;
            mtv_reg    <= mtv_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        addr_reg   <= addr_next;
        ok_reg     <= ok_next;
        res_reg    <= res_next;
        prod_reg   <= prod_next;
        rem_reg    <= rem_next;
        chk_reg    <= chk_next;
        quo_reg    <= quo_next;
        k_reg      <= k_next;
        i_reg      <= i_next;
        mok_reg    <= mok_next;
        maddr_reg  <= maddr_next;
        mcount_reg <= mcount_next;
    end

    assign m_tvalid = mtv_reg;
    assign m_tuser  = mok_reg;
    assign m_tdata  = {{(OUT_DATA_W - ADDR_W - CNT_W){1'b0}}, mcount_reg, maddr_reg};

    a_one_word_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted on back-to-back cycles");

    a_failed_has_null_address: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[ADDR_W-1:0] == '0))
        else $error("failed result carries a nonzero chunk address");

    a_no_link_write_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> !s_tready)
        else $error("link ram written while waiting for input");

endmodule

// ----- bench/fixed_block_pool_allocator_unit_tb.sv -----
// self-checking testbench for the fixed block pool allocator unit
`timescale 1ns / 1ps

module fixed_block_pool_allocator_unit_tb;
    import fbpa_pkg::*;

    localparam int DEPTH = POOL_DEPTH_DEF;
    localparam int QUIET_LIMIT = 20000;
    localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] chunk_addr;
        logic [CNT_W-1:0]  free_cnt;
    } pool_result_t;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        bit                drain;
    } pool_request_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [ADDR_W-1:0]     s_tdata = '0;    // address
    logic [OP_W-1:0]       s_tuser = '0;    // operation
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // chunk_address, free_count, zero pad
    logic                  m_tuser;         // ok
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ADDR_W-1:0]     cfg_data = '0;

    // model of the pool: configuration, link memory, head and counter
    logic [ADDR_W-1:0] pool_base = '0;
    logic [SIZE_W-1:0] pool_bytes = CHUNK_BYTES_RST;
    logic [CNT_W-1:0]  pool_count = CHUNK_COUNT_RST;
    logic [CNT_W-1:0]  link_next [0:DEPTH-1];
    logic              link_ok [0:DEPTH-1];
    logic [CNT_W-1:0]  head_idx = '0;
    logic              head_ok = 1'b0;
    logic [CNT_W-1:0]  free_total = '0;

    pool_request_t pending_requests[$];
    pool_result_t  expected_replies[$];
    pool_result_t  predicted;
    pool_result_t  got;
    pool_result_t  want;

    int unsigned send_idle_pct = 29;
    int unsigned recv_idle_pct = 63;
    int unsigned quiet_cycles = 0;
    int unsigned mismatches = 0;
    int unsigned n_words = 0;
    int unsigned n_inits = 0;
    int unsigned n_alloc_ok = 0;
    int unsigned n_alloc_refused = 0;
    int unsigned n_free_ok = 0;
    int unsigned n_free_rejected = 0;
    int unsigned n_unknown = 0;
    int unsigned n_reg_writes = 0;
    int unsigned peak_free = 0;

    fixed_block_pool_allocator_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic longint unsigned slot_bytes();
        return (pool_bytes < MIN_CHUNK) ? longint'(MIN_CHUNK) : longint'(pool_bytes);
    endfunction

    function automatic longint unsigned chunks_in_use();
        return (pool_count > DEPTH) ? longint'(DEPTH) : longint'(pool_count);
    endfunction

    function automatic pool_result_t pool_apply(input logic [OP_W-1:0] op,
                                                input logic [ADDR_W-1:0] a);
        pool_result_t r;
        longint unsigned sz;
        longint unsigned cnt;
        longint unsigned offset;
        longint unsigned idx;
        longint unsigned i;
        r = '0;
        sz = slot_bytes();
        cnt = chunks_in_use();
        case (op)
            OP_INIT: begin
                for (i = 0; i < cnt; i++) begin
                    link_next[i] = (i + 1 < cnt) ? CNT_W'(i + 1) : '0;
                    link_ok[i] = (i + 1 < cnt);
                end
                head_idx = '0;
                head_ok = (cnt > 0);
                free_total = CNT_W'(cnt);
                r.ok = (cnt > 0);
            end
            OP_ALLOC: begin
                if (head_ok) begin
                    idx = head_idx;
                    r.chunk_addr = ADDR_W'(pool_base + idx * sz);
                    head_idx = link_next[idx];
                    head_ok = link_ok[idx];
                    if (free_total != 0) free_total = free_total - 1'b1;
                    r.ok = 1'b1;
                end
            end
            OP_FREE: begin
                if (a != 0 && a >= pool_base) begin
                    offset = a;
                    offset = offset - pool_base;
                    if (offset < cnt * sz && offset % sz == 0) begin
                        idx = offset / sz;
                        link_next[idx] = head_idx;
                        link_ok[idx] = head_ok;
                        head_idx = CNT_W'(idx);
                        head_ok = 1'b1;
                        if (free_total != TOTAL_MAX) free_total = free_total + 1'b1;
                        r.ok = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.free_cnt = free_total;
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] pick_free_address();
        longint unsigned sz;
        longint unsigned cnt;
        longint unsigned idx;
        int unsigned sel;
        sz = slot_bytes();
        cnt = chunks_in_use();
        idx = (cnt == 0) ? 0 : $urandom_range(int'(cnt) - 1, 0);
        sel = $urandom_range(99);
        if (sel < 62) return ADDR_W'(pool_base + idx * sz);
        if (sel < 72) return ADDR_W'(pool_base + idx * sz + $urandom_range(int'(sz) - 1, 1));
        if (sel < 80) return ADDR_W'(pool_base + (cnt + $urandom_range(3, 0)) * sz);
        if (sel < 86) return pool_base - ADDR_W'($urandom_range(64, 1));
        if (sel < 91) return '0;
        return $urandom();
    endfunction

    // stimulus side of the input channel
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predicted = pool_apply(s_tuser, s_tdata);
                expected_replies.push_back(predicted);
                n_words++;
                if (predicted.free_cnt > peak_free) peak_free = predicted.free_cnt;
                case (s_tuser)
                    OP_INIT:  n_inits++;
                    OP_ALLOC: if (predicted.ok) n_alloc_ok++; else n_alloc_refused++;
                    OP_FREE:  if (predicted.ok) n_free_ok++; else n_free_rejected++;
                    default:  n_unknown++;
                endcase
            end
            if (!s_tvalid || s_tready) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct
                        && !(pending_requests[0].drain
                             && (s_tvalid || expected_replies.size() != 0))) begin
                    s_tvalid <= 1'b1;
                    s_tuser <= pending_requests[0].op;
                    s_tdata <= pending_requests[0].addr;
                    void'(pending_requests.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic flag_error(input string what);
        mismatches++;
        if (mismatches <= 10) $display("[%0t] %s", $realtime, what);
    endtask

    // result channel: backpressure and checking
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (m_tvalid && m_tready) begin
                got.ok = m_tuser;
                got.chunk_addr = m_tdata[ADDR_W-1:0];
                got.free_cnt = m_tdata[ADDR_W+CNT_W-1:ADDR_W];
                if (expected_replies.size() == 0) begin
                    flag_error($sformatf("unexpected word ok=%0d addr=%h count=%0d",
                                         got.ok, got.chunk_addr, got.free_cnt));
                end else begin
                    want = expected_replies.pop_front();
                    if (got !== want)
                        flag_error($sformatf(
                            "mismatch: exp ok=%0d addr=%h count=%0d, got ok=%0d addr=%h count=%0d",
                            want.ok, want.chunk_addr, want.free_cnt,
                            got.ok, got.chunk_addr, got.free_cnt));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic queue_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] a,
                                 input bit drain);
        pool_request_t req;
        req.op = op;
        req.addr = a;
        req.drain = drain;
        pending_requests.push_back(req);
    endtask

    // returns just after a rising edge with nothing in flight
    task automatic wait_idle();
        @(negedge aclk);
        while (pending_requests.size() != 0 || s_tvalid || expected_replies.size() != 0)
            @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic write_config(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] bytes,
                                input logic [CNT_W-1:0] count);
        logic [ADDR_W-1:0] values [3];
        int unsigned k;
        values[0] = base;
        values[1] = ADDR_W'(bytes);
        values[2] = ADDR_W'(count);
        for (k = 0; k < 3; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(k);
            cfg_data <= values[k];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            n_reg_writes++;
            case (CFG_IDX_W'(k))
                REG_POOL_BASE:   pool_base = values[k];
                REG_CHUNK_BYTES: pool_bytes = values[k][SIZE_W-1:0];
                REG_CHUNK_COUNT: pool_count = values[k][CNT_W-1:0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random_phase(input int unsigned n_req);
        logic [ADDR_W-1:0] b;
        logic [SIZE_W-1:0] sz;
        logic [CNT_W-1:0]  c;
        int unsigned sel;
        int unsigned k;
        sel = $urandom_range(99);
        if (sel < 20) b = '0;
        else if (sel < 50) b = $urandom() & 32'hFFFF_FF00;
        else if (sel < 65) b = 32'hFFFF_FFFF - $urandom_range(4095, 0);
        else b = $urandom();
        sel = $urandom_range(99);
        if (sel < 20) sz = SIZE_W'($urandom_range(15, 0));
        else if (sel < 50) sz = SIZE_W'(8 << $urandom_range(6, 0));
        else if (sel < 60) sz = 16'hFFFF;
        else sz = SIZE_W'($urandom());
        sel = $urandom_range(99);
        if (sel < 30) c = CNT_W'($urandom_range(8, 0));
        else if (sel < 70) c = CNT_W'($urandom_range(64, 1));
        else if (sel < 80) c = 11'd1024;
        else if (sel < 90) c = CNT_W'($urandom_range(2047, 1025));
        else c = CNT_W'($urandom());
        wait_idle();
        write_config(b, sz, c);
        queue_request(OP_INIT, $urandom(), 1'b0);
        for (k = 1; k < n_req; k++) begin
            sel = $urandom_range(99);
            if (sel < 44) queue_request(OP_ALLOC, $urandom(), sel < 2);
            else if (sel < 86) queue_request(OP_FREE, pick_free_address(), 1'b0);
            else if (sel < 93) queue_request(OP_INIT, $urandom(), 1'b0);
            else queue_request(OP_UNKNOWN, $urandom(), 1'b0);
        end
    endtask

    initial begin
        int unsigned k;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // defaults: null chunk at base zero, free before init, range and alignment
        queue_request(OP_ALLOC, 32'h0, 1'b0);
        queue_request(OP_UNKNOWN, 32'hFFFF_FFFF, 1'b0);
        queue_request(OP_FREE, 32'h0, 1'b0);
        queue_request(OP_FREE, 32'h8, 1'b0);
        queue_request(OP_INIT, 32'h0, 1'b0);
        queue_request(OP_ALLOC, 32'h0, 1'b0);
        queue_request(OP_ALLOC, 32'h0, 1'b0);
        queue_request(OP_FREE, 32'hC, 1'b0);
        queue_request(OP_FREE, 32'h2000, 1'b0);
        queue_request(OP_FREE, 32'h1FF8, 1'b0);
        queue_request(OP_FREE, 32'hFFFF_FFFF, 1'b0);
        queue_request(OP_ALLOC, 32'hFFFF_FFFF, 1'b1);

        // count clamped to depth, a free address that wraps past 2^32 is rejected
        wait_idle();
        write_config(32'hFFFF_F000, 16'h0800, 11'd2047);
        queue_request(OP_INIT, 32'h0, 1'b0);
        queue_request(OP_ALLOC, 32'h0, 1'b0);
        queue_request(OP_ALLOC, 32'h0, 1'b0);
        queue_request(OP_FREE, 32'hFFFF_F800, 1'b0);
        queue_request(OP_FREE, 32'h0000_0800, 1'b0);

        // zero count, then a chunk size below the minimum of 8 bytes
        wait_idle();
        write_config(32'h100, 16'd3, 11'd0);
        queue_request(OP_INIT, 32'h0, 1'b0);
        queue_request(OP_ALLOC, 32'h0, 1'b0);
        wait_idle();
        write_config(32'h100, 16'd3, 11'd2);
        queue_request(OP_INIT, 32'h0, 1'b0);
        queue_request(OP_ALLOC, 32'h0, 1'b0);
        queue_request(OP_ALLOC, 32'h0, 1'b0);
        queue_request(OP_FREE, 32'h104, 1'b0);

        // top of the address space with the largest chunk
        wait_idle();
        write_config(32'hFFFF_FFFF, 16'hFFFF, 11'd1);
        queue_request(OP_INIT, 32'h0, 1'b0);
        queue_request(OP_ALLOC, 32'h0, 1'b0);
        queue_request(OP_FREE, 32'hFFFF_FFFF, 1'b0);

        // double free loops the list, allocation then holds the counter at zero
        wait_idle();
        write_config(32'h4000, 16'd16, 11'd1);
        queue_request(OP_INIT, 32'h0, 1'b0);
        queue_request(OP_FREE, 32'h4000, 1'b0);
        queue_request(OP_ALLOC, 32'h0, 1'b0);
        queue_request(OP_ALLOC, 32'h0, 1'b0);
        queue_request(OP_ALLOC, 32'h0, 1'b0);

        for (k = 0; k < 9; k++) begin
            if (k == 3) begin
                send_idle_pct = 63;
                recv_idle_pct = 29;
            end else if (k == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            run_random_phase(32);
        end

        // push the counter into saturation, then pop a few chunks
        wait_idle();
        write_config(($urandom() & 32'h7FFF_FFF8) | 32'h0000_1000, 16'd8, 11'd1024);
        queue_request(OP_INIT, $urandom(), 1'b0);
        for (k = 0; k < 1028; k++)
            queue_request(OP_FREE, pool_base + 32'($urandom_range(1023, 0) * 8), 1'b0);
        for (k = 0; k < 8; k++)
            queue_request(OP_ALLOC, $urandom(), 1'b0);

        wait_idle();
        repeat (40) @(posedge aclk);
        $display("covered %0d words: %0d initializations, %0d allocations granted, %0d refused",
                 n_words, n_inits, n_alloc_ok, n_alloc_refused);
        $display("%0d frees taken, %0d rejected, %0d unknown ops, peak free count %0d, %0d reg writes",
                 n_free_ok, n_free_rejected, n_unknown, peak_free, n_reg_writes);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
